/* hw/rtl/mpwl_pkg.sv */
package mpwl_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_addr;

    localparam t_cfg_addr CFG_SIXTEEN_BIT       = 3'd0;
    localparam t_cfg_addr CFG_HIGH_BIT          = 3'd1;
    localparam t_cfg_addr CFG_SIGNED_PIXELS     = 3'd2;
    localparam t_cfg_addr CFG_RESCALE_ON        = 3'd3;
    localparam t_cfg_addr CFG_RESCALE_SLOPE     = 3'd4;
    localparam t_cfg_addr CFG_RESCALE_INTERCEPT = 3'd5;
    localparam t_cfg_addr CFG_WINDOW_SHIFT      = 3'd6;
    localparam t_cfg_addr CFG_WINDOW_GAIN       = 3'd7;

    localparam int CFG_DATA_W = 32;

    // 1.0 in Q15.16
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    localparam logic [7:0] GREY_MAX = 8'd255;

    typedef struct packed {
        logic               sixteen_bit;
        logic [3:0]         high_bit;
        logic               signed_pixels;
        logic               rescale_on;
        logic signed [31:0] rescale_slope;
        logic signed [31:0] rescale_intercept;
        logic signed [17:0] window_shift;
        logic [24:0]        window_gain;
    } t_cfg;

    typedef struct packed {
        logic [15:0] raw_sample;
        logic        last_in;
    } t_in_req;

    typedef struct packed {
        logic [7:0] grey;
        logic       format_error;
        logic       last_out;
    } t_out_req;

endpackage

/* hw/rtl/mpwl_cfg_regs.sv */
module mpwl_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  mpwl_pkg::t_cfg_addr                 i_cfg_addr,
    input  logic [mpwl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output mpwl_pkg::t_cfg                      o_cfg
);

    mpwl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sixteen_bit       <= 1'b1;
            r_cfg.high_bit          <= 4'd11;
            r_cfg.signed_pixels     <= 1'b0;
            r_cfg.rescale_on        <= 1'b0;
            r_cfg.rescale_slope     <= mpwl_pkg::ONE_Q16;
            r_cfg.rescale_intercept <= '0;
            r_cfg.window_shift      <= '0;
            r_cfg.window_gain       <= 25'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mpwl_pkg::CFG_SIXTEEN_BIT:       r_cfg.sixteen_bit       <= i_cfg_wdata[0];
                mpwl_pkg::CFG_HIGH_BIT:          r_cfg.high_bit          <= i_cfg_wdata[3:0];
                mpwl_pkg::CFG_SIGNED_PIXELS:     r_cfg.signed_pixels     <= i_cfg_wdata[0];
                mpwl_pkg::CFG_RESCALE_ON:        r_cfg.rescale_on        <= i_cfg_wdata[0];
                mpwl_pkg::CFG_RESCALE_SLOPE:     r_cfg.rescale_slope     <= i_cfg_wdata;
                mpwl_pkg::CFG_RESCALE_INTERCEPT: r_cfg.rescale_intercept <= i_cfg_wdata;
                mpwl_pkg::CFG_WINDOW_SHIFT:      r_cfg.window_shift      <= i_cfg_wdata[17:0];
                mpwl_pkg::CFG_WINDOW_GAIN:       r_cfg.window_gain       <= i_cfg_wdata[24:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/mpwl_rescale.sv */
module mpwl_rescale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpwl_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  mpwl_pkg::t_in_req   i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [18:0]  o_diff,
    output logic                o_last
);

    // stage enables, ready chain from the back
    logic en1, en2, en3, en4;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_last1, r_last2, r_last3, r_last4;

    logic signed [16:0] r_x1;
    logic signed [48:0] r_prod2;
    logic               r_neg3;
    logic [31:0]        r_low3;
    logic signed [18:0] r_diff4;

    logic signed16;
    assign signed16 = i_cfg.sixteen_bit & i_cfg.signed_pixels;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    // stage 1: clip to stored bits
    logic [15:0] s_in;
    logic [15:0] clip;
    logic signed [16:0] n_x1;

    always_comb begin
        s_in = i_cfg.sixteen_bit ? i_req.raw_sample : {8'h00, i_req.raw_sample[7:0]};
        for (int i = 0; i < 16; i++) begin
            if (i > int'(i_cfg.high_bit)) begin
                clip[i] = signed16 & s_in[i_cfg.high_bit];
            end else begin
                clip[i] = s_in[i];
            end
        end
        n_x1 = signed16 ? $signed({clip[15], clip}) : $signed({1'b0, clip});
    end

    // stage 2: sample times slope (unity when rescale is off)
    logic signed [31:0] slope_eff;
    logic signed [48:0] n_prod2;
    assign slope_eff = i_cfg.rescale_on ? i_cfg.rescale_slope : mpwl_pkg::ONE_Q16;
    assign n_prod2   = r_x1 * slope_eff;

    // stage 3: add intercept
    logic signed [31:0] icpt_eff;
    logic signed [49:0] sum3;
    assign icpt_eff = i_cfg.rescale_on ? i_cfg.rescale_intercept : 32'sd0;
    assign sum3     = r_prod2 + icpt_eff;

    // stage 4: truncate toward zero, wrap, window offset
    logic        corr;
    logic [15:0] q;
    logic [15:0] qw;
    logic        sgn_win;
    logic signed [16:0] val;
    logic signed [18:0] n_diff4;

    always_comb begin
        corr    = r_neg3 && (|r_low3[15:0]);
        q       = r_low3[31:16] + {15'd0, corr};
        qw      = i_cfg.sixteen_bit ? q : {8'h00, q[7:0]};
        sgn_win = i_cfg.sixteen_bit
                  && (i_cfg.signed_pixels
                      || (i_cfg.rescale_on && i_cfg.rescale_intercept[31]));
        val     = sgn_win ? $signed({qw[15], qw}) : $signed({1'b0, qw});
        n_diff4 = val - i_cfg.window_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x1    <= n_x1;
            r_last1 <= i_req.last_in;
        end
        if (en2) begin
            r_prod2 <= n_prod2;
            r_last2 <= r_last1;
        end
        if (en3) begin
            r_neg3  <= sum3[49];
            r_low3  <= sum3[31:0];
            r_last3 <= r_last2;
        end
        if (en4) begin
            r_diff4 <= n_diff4;
            r_last4 <= r_last3;
        end
    end

    assign o_valid = r_v4;
    assign o_diff  = r_diff4;
    assign o_last  = r_last4;

endmodule

/* hw/rtl/mpwl_window.sv */
module mpwl_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpwl_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [18:0]  i_diff,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output mpwl_pkg::t_out_req  o_rsp
);

    logic en5, en6;
    logic r_v5, r_v6;
    logic r_last5;
    logic signed [44:0] r_prod5;
    mpwl_pkg::t_out_req r_rsp;

    assign en6     = !r_v6 || !i_stall;
    assign en5     = !r_v5 || en6;
    assign o_stall = !en5;

    // stage 5: gain multiply, Q.16 result
    logic signed [25:0] gain_s;
    logic signed [44:0] n_prod5;
    assign gain_s  = $signed({1'b0, i_cfg.window_gain});
    assign n_prod5 = i_diff * gain_s;

    // stage 6: floor and clamp to 0..255
    logic fmt_err;
    mpwl_pkg::t_out_req n_rsp;

    always_comb begin
        fmt_err            = !i_cfg.sixteen_bit && i_cfg.signed_pixels;
        n_rsp.format_error = fmt_err;
        n_rsp.last_out     = r_last5;
        if (fmt_err || r_prod5[44]) begin
            n_rsp.grey = 8'd0;
        end else if (|r_prod5[43:24]) begin
            n_rsp.grey = mpwl_pkg::GREY_MAX;
        end else begin
            n_rsp.grey = r_prod5[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en5) r_v5 <= i_valid;
            if (en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_prod5 <= n_prod5;
            r_last5 <= i_last;
        end
        if (en6) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_v6;
    assign o_rsp   = r_rsp;

endmodule

/* hw/rtl/mono_pixel_window_level.sv */
// Window/level mapping of a monochrome pixel stream to 8-bit grey. Each request
// carries one raw 8- or 16-bit sample; the block clips it to its stored bits,
// applies the optional slope/intercept rescale (truncated toward zero, wrapped
// to the sample width), subtracts window_shift, scales by window_gain (Q9.16)
// and clamps to 0..255. Signed 8-bit data sets format_error with grey 0.
// Throughput is one request per clock unless stalled. Six registers: clip,
// slope multiply, intercept add, truncate and offset, gain multiply, clamp;
// the two 17x32 and 19x26 multipliers each own a stage. The user must write
// configuration registers only while the pipe is empty, unchecked by the block.
module mono_pixel_window_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  mpwl_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [mpwl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel requests in
    input  logic                            i_valid,
    output logic                            o_stall,
    input  mpwl_pkg::t_in_req               i_req,
    // grey results out
    output logic                            o_valid,
    input  logic                            i_stall,
    output mpwl_pkg::t_out_req              o_rsp
);

    mpwl_pkg::t_cfg cfg;

    // handoff between rescale and window halves
    logic               mid_valid;
    logic               mid_stall;
    logic signed [18:0] mid_diff;
    logic               mid_last;

    mpwl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // stages 1-4: clip, rescale, truncate/wrap, window offset
    mpwl_rescale u_rescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (mid_valid),
        .i_stall (mid_stall),
        .o_diff  (mid_diff),
        .o_last  (mid_last)
    );

    // stages 5-6: gain and clamp; stage 6 is the output register
    mpwl_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mid_valid),
        .o_stall (mid_stall),
        .i_diff  (mid_diff),
        .i_last  (mid_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // format error always forces black
    a_fmt_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.format_error |-> o_rsp.grey == 8'd0)
        else $error("format_error with nonzero grey");

    // input backpressure only when the whole pipe is full behind a held result
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output");

    // an unstalled pipe never blocks the midpoint handoff
    a_mid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !mid_stall)
        else $error("midpoint stalled while output drains");

endmodule
